[hdl/accumulator_register_execute_unit_assert.svh]
// Assertion macros for the accumulator register execute unit.
`ifndef ACCUMULATOR_REGISTER_EXECUTE_UNIT_ASSERT_SVH
`define ACCUMULATOR_REGISTER_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AREU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("areu assertion failed");

// Next-cycle implication, disabled during reset.
`define AREU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("areu assertion failed");

`endif

[hdl/areu_pkg.sv]
// Package with types and constants of the accumulator register execute unit.
`default_nettype none

package areu_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int BYTE_WIDTH = 8;
   localparam int MODE_WIDTH = 5;
   localparam int KIND_WIDTH = 2;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [BYTE_WIDTH-1:0] byte_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_TAX, OP_TAY,
      OP_TSX, OP_TXA, OP_TXS, OP_TYA, OP_PHA, OP_PHP, OP_PLA, OP_PLP,
      OP_DEC, OP_DEX, OP_DEY, OP_INC, OP_INX, OP_INY, OP_ADC, OP_SBC,
      OP_AND, OP_EOR, OP_ORA, OP_ASLA, OP_ASLM, OP_LSRA, OP_LSRM, OP_NOP
   } op_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      WRITE_NONE = 2'd0,
      WRITE_WORD = 2'd1,
      WRITE_BYTE = 2'd2
   } write_kind_type;

   // Packed low field last: acc sits in the lowest bits.
   typedef struct packed {
      byte_type store_byte;
      word_type store_word;
      byte_type status;
      word_type stack_ptr;
      word_type y_reg;
      word_type x_reg;
      word_type acc;
   } result_type;

   localparam int REQ_DATA_WIDTH = ((DATA_WIDTH + BYTE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = (($bits(result_type) + 7) / 8) * 8;

endpackage

`default_nettype wire

[hdl/accumulator_register_execute_unit.sv]
// Execute unit: accumulator, X, Y, stack pointer and status with one ALU pass.
//
// Usage:
//   req_ channel carries one instruction per item: mode in req_tuser, the
//   fetched operand word and memory byte in req_tdata.
//   rsp_ channel returns one item per instruction: the register file after
//   it, the store data, and the write kind in rsp_tuser.
// Path: an accepted item is held in the input register; its result moves
//   into the result register once the output side can take it.
// Throughput: one item per cycle while rsp_tready is high. The single ALU
//   pass from the input register through the architectural registers into
//   the result register sets this; each item sees the state left by its predecessor.
// Stall: while rsp_tready is low the result holds, one more item waits in
//   the input register, and req_tready drops once both are full.
// Reset: synchronous; clears A, X, Y, SP, the status byte and both valid
//   bits. No item is in flight after reset.
`default_nettype none

`include "accumulator_register_execute_unit_assert.svh"

module accumulator_register_execute_unit
   import areu_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,  // operand_value, mem_byte
   input  wire logic [MODE_WIDTH-1:0]     req_tuser,  // mode
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,  // acc, x_reg, y_reg, stack_ptr,
                                                      // status, store_word, store_byte
   output logic [KIND_WIDTH-1:0]          rsp_tuser   // write_kind
);

   logic           in_valid_ff;
   op_type         in_op_ff;
   word_type       in_word_ff;
   byte_type       in_byte_ff;

   word_type       acc_ff, x_ff, y_ff, sp_ff;
   byte_type       flags_ff;
   word_type       acc_in, x_in, y_in, sp_in;
   byte_type       flags_in;

   logic           rsp_valid_ff;
   result_type     out_ff;
   result_type     out_in;
   write_kind_type kind_ff;
   write_kind_type kind_in;

   logic           out_ready;
   logic           advance;

   word_type                add_b;
   logic [DATA_WIDTH:0]     sum;
   word_type                sum_word;
   byte_type                byte_res;

   function automatic byte_type word_zn(input byte_type f, input word_type w);
      byte_type r;
      r = f;
      r[FLAG_Z] = (w == '0);
      r[FLAG_N] = w[DATA_WIDTH-1];
      return r;
   endfunction

   function automatic byte_type byte_zn(input byte_type f, input byte_type b);
      byte_type r;
      r = f;
      r[FLAG_Z] = (b == '0);
      r[FLAG_N] = 1'b0;
      return r;
   endfunction

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   assign add_b    = (in_op_ff == OP_SBC) ? ~in_word_ff : in_word_ff;
   assign sum      = {1'b0, acc_ff} + {1'b0, add_b} + (DATA_WIDTH+1)'(flags_ff[FLAG_C]);
   assign sum_word = sum[DATA_WIDTH-1:0];

   always_comb begin
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      sp_in    = sp_ff;
      flags_in = flags_ff;
      out_in   = '0;
      kind_in  = WRITE_NONE;
      byte_res = '0;
      unique case (in_op_ff)
         OP_LDA, OP_PLA: begin
            acc_in   = in_word_ff;
            flags_in = word_zn(flags_ff, in_word_ff);
         end
         OP_LDX: begin
            x_in     = in_word_ff;
            flags_in = word_zn(flags_ff, in_word_ff);
         end
         OP_LDY: begin
            y_in     = in_word_ff;
            flags_in = word_zn(flags_ff, in_word_ff);
         end
         OP_STA, OP_PHA: begin
            out_in.store_word = acc_ff;
            kind_in           = WRITE_WORD;
         end
         OP_STX: begin
            out_in.store_word = x_ff;
            kind_in           = WRITE_WORD;
         end
         OP_STY: begin
            out_in.store_word = y_ff;
            kind_in           = WRITE_WORD;
         end
         OP_TAX: begin
            x_in     = acc_ff;
            flags_in = word_zn(flags_ff, acc_ff);
         end
         OP_TAY: begin
            y_in     = acc_ff;
            flags_in = word_zn(flags_ff, acc_ff);
         end
         OP_TSX: begin
            x_in     = sp_ff;
            flags_in = word_zn(flags_ff, sp_ff);
         end
         OP_TXA: begin
            acc_in   = x_ff;
            flags_in = word_zn(flags_ff, x_ff);
         end
         OP_TXS: begin
            sp_in = x_ff;
         end
         OP_TYA: begin
            acc_in   = y_ff;
            flags_in = word_zn(flags_ff, y_ff);
         end
         OP_PHP: begin
            out_in.store_byte = flags_ff;
            kind_in           = WRITE_BYTE;
         end
         OP_PLP: begin
            flags_in = in_word_ff[BYTE_WIDTH-1:0];
         end
         OP_DEC: begin
            byte_res          = in_byte_ff - 8'd1;
            flags_in          = byte_zn(flags_ff, byte_res);
            out_in.store_byte = byte_res;
            kind_in           = WRITE_BYTE;
         end
         OP_INC: begin
            byte_res          = in_byte_ff + 8'd1;
            flags_in          = byte_zn(flags_ff, byte_res);
            out_in.store_byte = byte_res;
            kind_in           = WRITE_BYTE;
         end
         OP_DEX: begin
            x_in     = x_ff - word_type'(1);
            flags_in = word_zn(flags_ff, x_in);
         end
         OP_DEY: begin
            y_in     = y_ff - word_type'(1);
            flags_in = word_zn(flags_ff, y_in);
         end
         OP_INX: begin
            x_in     = x_ff + word_type'(1);
            flags_in = word_zn(flags_ff, x_in);
         end
         OP_INY: begin
            y_in     = y_ff + word_type'(1);
            flags_in = word_zn(flags_ff, y_in);
         end
         OP_ADC, OP_SBC: begin
            acc_in           = sum_word;
            flags_in         = word_zn(flags_ff, sum_word);
            flags_in[FLAG_C] = sum[DATA_WIDTH];
            flags_in[FLAG_V] = ~(acc_ff[DATA_WIDTH-1] ^ add_b[DATA_WIDTH-1])
                               & (acc_ff[DATA_WIDTH-1] ^ sum_word[DATA_WIDTH-1]);
         end
         OP_AND: begin
            acc_in   = acc_ff & in_word_ff;
            flags_in = word_zn(flags_ff, acc_in);
         end
         OP_EOR: begin
            acc_in   = acc_ff ^ in_word_ff;
            flags_in = word_zn(flags_ff, acc_in);
         end
         OP_ORA: begin
            acc_in   = acc_ff | in_word_ff;
            flags_in = word_zn(flags_ff, acc_in);
         end
         OP_ASLA: begin
            acc_in           = {acc_ff[DATA_WIDTH-2:0], 1'b0};
            flags_in         = word_zn(flags_ff, acc_in);
            flags_in[FLAG_C] = acc_ff[DATA_WIDTH-1];
         end
         OP_LSRA: begin
            acc_in           = {1'b0, acc_ff[DATA_WIDTH-1:1]};
            flags_in         = word_zn(flags_ff, acc_in);
            flags_in[FLAG_C] = acc_ff[0];
         end
         OP_ASLM: begin
            byte_res          = {in_byte_ff[BYTE_WIDTH-2:0], 1'b0};
            flags_in          = byte_zn(flags_ff, byte_res);
            flags_in[FLAG_C]  = in_byte_ff[BYTE_WIDTH-1];
            out_in.store_byte = byte_res;
            kind_in           = WRITE_BYTE;
         end
         OP_LSRM: begin
            byte_res          = {1'b0, in_byte_ff[BYTE_WIDTH-1:1]};
            flags_in          = byte_zn(flags_ff, byte_res);
            flags_in[FLAG_C]  = in_byte_ff[0];
            out_in.store_byte = byte_res;
            kind_in           = WRITE_BYTE;
         end
         OP_NOP: begin
         end
      endcase
      out_in.acc       = acc_in;
      out_in.x_reg     = x_in;
      out_in.y_reg     = y_in;
      out_in.stack_ptr = sp_in;
      out_in.status    = flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         sp_ff        <= '0;
         flags_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_ready) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            acc_ff   <= acc_in;
            x_ff     <= x_in;
            y_ff     <= y_in;
            sp_ff    <= sp_in;
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_op_ff   <= op_type'(req_tuser);
         in_word_ff <= req_tdata[DATA_WIDTH-1:0];
         in_byte_ff <= req_tdata[DATA_WIDTH+BYTE_WIDTH-1:DATA_WIDTH];
      end
      if (advance) begin
         out_ff  <= out_in;
         kind_ff <= kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'(out_ff);
   assign rsp_tuser  = kind_ff;

   `AREU_ASSERT_IMPL(a_no_write_no_data, clock, reset,
      rsp_valid_ff && kind_ff == WRITE_NONE,
      out_ff.store_word == '0 && out_ff.store_byte == '0)
   `AREU_ASSERT_IMPL(a_kind_data_match, clock, reset,
      rsp_valid_ff,
      (kind_ff == WRITE_WORD && out_ff.store_byte == '0)
      || (kind_ff == WRITE_BYTE && out_ff.store_word == '0)
      || kind_ff == WRITE_NONE)
   `AREU_ASSERT_NEXT(a_sp_only_txs, clock, reset,
      !(advance && in_op_ff == OP_TXS), $stable(sp_ff))
   `AREU_ASSERT_NEXT(a_stall_holds_item, clock, reset,
      in_valid_ff && !out_ready, in_valid_ff && rsp_valid_ff)

endmodule

`default_nettype wire

[dv/accumulator_register_execute_unit_test.sv]
// Self-checking testbench for the accumulator register execute unit.
`default_nettype none

module accumulator_register_execute_unit_test
   import areu_pkg::*;
;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int MSB = DATA_WIDTH - 1;

   typedef struct packed {
      result_type     data;
      write_kind_type kind;
   } exec_outcome_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic [MODE_WIDTH-1:0]     req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [KIND_WIDTH-1:0]     rsp_tuser;

   word_type model_acc, model_x, model_y, model_sp;
   byte_type model_status;

   exec_outcome_type expected_regfile_q[$];
   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int op_seen[32];
   bit sender_steady = 0;
   bit receiver_steady = 0;
   int hold_request = 0;

   accumulator_register_execute_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic void set_word_flags(word_type w);
      model_status[FLAG_Z] = (w == '0);
      model_status[FLAG_N] = w[MSB];
   endfunction

   function automatic void set_byte_flags(byte_type b);
      model_status[FLAG_Z] = (b == '0);
      model_status[FLAG_N] = 1'b0;
   endfunction

   // Advances the register file by one instruction and returns what the unit should emit.
   function automatic exec_outcome_type predict_execute(op_type op, word_type opw, byte_type mb);
      exec_outcome_type res;
      logic [DATA_WIDTH:0] sum;
      word_type addend;
      res = '0;
      res.kind = WRITE_NONE;
      case (op)
         OP_LDA, OP_PLA: begin model_acc = opw; set_word_flags(model_acc); end
         OP_LDX: begin model_x = opw; set_word_flags(model_x); end
         OP_LDY: begin model_y = opw; set_word_flags(model_y); end
         OP_STA, OP_PHA: begin res.data.store_word = model_acc; res.kind = WRITE_WORD; end
         OP_STX: begin res.data.store_word = model_x; res.kind = WRITE_WORD; end
         OP_STY: begin res.data.store_word = model_y; res.kind = WRITE_WORD; end
         OP_TAX: begin model_x = model_acc; set_word_flags(model_x); end
         OP_TAY: begin model_y = model_acc; set_word_flags(model_y); end
         OP_TSX: begin model_x = model_sp; set_word_flags(model_x); end
         OP_TXA: begin model_acc = model_x; set_word_flags(model_acc); end
         OP_TXS: model_sp = model_x;
         OP_TYA: begin model_acc = model_y; set_word_flags(model_acc); end
         OP_PHP: begin res.data.store_byte = model_status; res.kind = WRITE_BYTE; end
         OP_PLP: model_status = opw[BYTE_WIDTH-1:0];
         OP_DEC: begin
            res.data.store_byte = mb - 8'd1;
            set_byte_flags(res.data.store_byte);
            res.kind = WRITE_BYTE;
         end
         OP_INC: begin
            res.data.store_byte = mb + 8'd1;
            set_byte_flags(res.data.store_byte);
            res.kind = WRITE_BYTE;
         end
         OP_DEX: begin model_x = model_x - word_type'(1); set_word_flags(model_x); end
         OP_DEY: begin model_y = model_y - word_type'(1); set_word_flags(model_y); end
         OP_INX: begin model_x = model_x + word_type'(1); set_word_flags(model_x); end
         OP_INY: begin model_y = model_y + word_type'(1); set_word_flags(model_y); end
         OP_ADC, OP_SBC: begin
            addend = (op == OP_SBC) ? ~opw : opw;
            sum = {1'b0, model_acc} + {1'b0, addend}
                  + (DATA_WIDTH+1)'(model_status[FLAG_C]);
            model_status[FLAG_V] = ~(model_acc[MSB] ^ addend[MSB]) & (model_acc[MSB] ^ sum[MSB]);
            model_status[FLAG_C] = sum[DATA_WIDTH];
            model_acc = sum[DATA_WIDTH-1:0];
            set_word_flags(model_acc);
         end
         OP_AND: begin model_acc = model_acc & opw; set_word_flags(model_acc); end
         OP_EOR: begin model_acc = model_acc ^ opw; set_word_flags(model_acc); end
         OP_ORA: begin model_acc = model_acc | opw; set_word_flags(model_acc); end
         OP_ASLA: begin
            model_status[FLAG_C] = model_acc[MSB];
            model_acc = model_acc << 1;
            set_word_flags(model_acc);
         end
         OP_LSRA: begin
            model_status[FLAG_C] = model_acc[0];
            model_acc = model_acc >> 1;
            set_word_flags(model_acc);
         end
         OP_ASLM: begin
            model_status[FLAG_C] = mb[BYTE_WIDTH-1];
            res.data.store_byte = mb << 1;
            set_byte_flags(res.data.store_byte);
            res.kind = WRITE_BYTE;
         end
         OP_LSRM: begin
            model_status[FLAG_C] = mb[0];
            res.data.store_byte = mb >> 1;
            set_byte_flags(res.data.store_byte);
            res.kind = WRITE_BYTE;
         end
         default: ;
      endcase
      res.data.acc = model_acc;
      res.data.x_reg = model_x;
      res.data.y_reg = model_y;
      res.data.stack_ptr = model_sp;
      res.data.status = model_status;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (sender_steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << MSB;
         3: return ~(word_type'(1) << MSB);
         4: return word_type'(1);
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic byte_type pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h01;
         default: return byte_type'($urandom);
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_instr(op_type op, word_type opw, byte_type mb);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = '0;
      req_tdata[DATA_WIDTH+BYTE_WIDTH-1:0] = {mb, opw};
      do @(posedge clock); while (!req_tready);
      expected_regfile_q.push_back(predict_execute(op, opw, mb));
      op_seen[op]++;
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_instr();
      send_instr(op_type'($urandom_range(0, 31)), pick_word(), pick_byte());
   endtask

   task automatic wait_results_drained();
      req_tvalid = 1'b0;
      while (expected_regfile_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic test_directed_ops();
      send_instr(OP_PLP, 16'hFFFF, 8'h00);
      send_instr(OP_PHP, 16'h0000, 8'h00);
      send_instr(OP_PLP, 16'hFF00, 8'hFF);
      send_instr(OP_LDA, 16'h0000, 8'h00);
      send_instr(OP_LDX, 16'hFFFF, 8'h00);
      send_instr(OP_LDY, 16'h8000, 8'h00);
      send_instr(OP_STA, 16'hFFFF, 8'hFF);
      send_instr(OP_STX, 16'h0000, 8'h00);
      send_instr(OP_STY, 16'h0000, 8'h00);
      send_instr(OP_TXS, 16'h0000, 8'h00);
      send_instr(OP_TSX, 16'h0000, 8'h00);
      send_instr(OP_TAX, 16'h0000, 8'h00);
      send_instr(OP_TAY, 16'h0000, 8'h00);
      send_instr(OP_TXA, 16'h0000, 8'h00);
      send_instr(OP_TYA, 16'h0000, 8'h00);
      send_instr(OP_PHA, 16'h5555, 8'hAA);
      send_instr(OP_PLA, 16'h7FFF, 8'h00);
      // signed overflow, then carry out with zero result
      send_instr(OP_ADC, 16'h0001, 8'h00);
      send_instr(OP_ADC, 16'h8000, 8'h00);
      // subtract without borrow, then with borrow
      send_instr(OP_SBC, 16'h0000, 8'h00);
      send_instr(OP_SBC, 16'h0001, 8'h00);
      send_instr(OP_AND, 16'h80FF, 8'h00);
      send_instr(OP_EOR, 16'hFFFF, 8'h00);
      send_instr(OP_ORA, 16'h8000, 8'h00);
      send_instr(OP_ASLA, 16'h0000, 8'h00);
      send_instr(OP_LSRA, 16'h0000, 8'h00);
      // memory byte ops clear N even when bit 7 of the byte is set
      send_instr(OP_INC, 16'h0000, 8'hFF);
      send_instr(OP_DEC, 16'h0000, 8'h00);
      send_instr(OP_ASLM, 16'h0000, 8'h80);
      send_instr(OP_LSRM, 16'h0000, 8'h01);
      send_instr(OP_DEX, 16'h0000, 8'h00);
      send_instr(OP_DEY, 16'h0000, 8'h00);
      send_instr(OP_INX, 16'h0000, 8'h00);
      send_instr(OP_INY, 16'h0000, 8'h00);
      send_instr(OP_NOP, 16'hA5A5, 8'h5A);
   endtask

   task automatic test_output_backpressure();
      sender_steady = 1'b1;
      hold_request = 250;
      repeat (24) send_random_instr();
      sender_steady = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      repeat (20) send_random_instr();
      wait_results_drained();
      repeat (20) send_random_instr();
   endtask

   task automatic test_steady_stream();
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      repeat (150) send_random_instr();
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   task automatic test_random_stream(int count);
      repeat (count) send_random_instr();
   endtask

   // Output side: random stalls, rare long ones, and hold-offs on request.
   initial begin : rsp_receiver
      int hold_left;
      int stall_left;
      int r;
      hold_left = 0;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (receiver_steady) begin
            rsp_tready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               stall_left = $urandom_range(10, 40);
               rsp_tready = 1'b0;
            end else begin
               rsp_tready = (r >= 25);
            end
         end
      end
   end

   task automatic check_field(string name, logic [DATA_WIDTH-1:0] exp_v,
                              logic [DATA_WIDTH-1:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: result %0d %s mismatch, expected %h, got %h",
                  $time, results_checked, name, exp_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_checker
      exec_outcome_type exp_r;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(result_type)-1:0];
         if (expected_regfile_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
            error_count++;
         end else begin
            exp_r = expected_regfile_q.pop_front();
            check_field("acc", exp_r.data.acc, got.acc);
            check_field("x_reg", exp_r.data.x_reg, got.x_reg);
            check_field("y_reg", exp_r.data.y_reg, got.y_reg);
            check_field("stack_ptr", exp_r.data.stack_ptr, got.stack_ptr);
            check_field("status", word_type'(exp_r.data.status), word_type'(got.status));
            check_field("store_word", exp_r.data.store_word, got.store_word);
            check_field("store_byte", word_type'(exp_r.data.store_byte),
                        word_type'(got.store_byte));
            check_field("write_kind", word_type'(exp_r.kind), word_type'(rsp_tuser));
         end
         results_checked++;
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : main_sequence
      int ops_covered;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_NOP;
      reset = 1'b1;
      model_acc = '0;
      model_x = '0;
      model_y = '0;
      model_sp = '0;
      model_status = '0;
      foreach (op_seen[i]) op_seen[i] = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed_ops();
      test_output_backpressure();
      test_pause_until_drained();
      test_steady_stream();
      test_random_stream(800);
      wait_results_drained();

      ops_covered = 0;
      foreach (op_seen[i]) if (op_seen[i] > 0) ops_covered++;
      $display("Sent %0d instructions covering %0d of 32 operations; %0d results checked.",
               items_sent, ops_covered, results_checked);
      $display("Included long output hold-off, a full drain pause and back-to-back bursts.");
      if (error_count == 0 && expected_regfile_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
